### src/encoder_menu_pwm_setpoint_core_assert.svh
`ifndef ENCODER_MENU_PWM_SETPOINT_CORE_ASSERT_SVH
`define ENCODER_MENU_PWM_SETPOINT_CORE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define EMPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("emps check failed");

// next-cycle implication, checked while out of reset
`define EMPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("emps check failed");

`endif

### src/emps_pkg.sv
package emps_pkg;

    localparam int EMPS_TIMER_BITS = 16;

    // event kinds
    localparam logic [1:0] OP_ENC  = 2'd0;
    localparam logic [1:0] OP_SEL  = 2'd1;
    localparam logic [1:0] OP_STEP = 2'd2;

    // menu pages
    localparam logic [1:0] PAGE_FRONT = 2'd0;
    localparam logic [1:0] PAGE_SETUP = 2'd1;
    localparam logic [1:0] PAGE_DUTY  = 2'd2;
    localparam logic [1:0] PAGE_FREQ  = 2'd3;

    // drive modes
    localparam logic [1:0] DRV_STOP = 2'd0;
    localparam logic [1:0] DRV_LOW  = 2'd1;
    localparam logic [1:0] DRV_HIGH = 2'd2;
    localparam logic [1:0] DRV_RUN  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_PERIOD_TOP   = 2'd0;
    localparam logic [1:0] CFG_PRESCALE_NUM = 2'd1;
    localparam logic [1:0] CFG_FREQ_MAX     = 2'd2;

    // reset values
    localparam logic [15:0] RST_PERIOD_TOP   = 16'd1399;
    localparam logic [15:0] RST_PRESCALE_NUM = 16'd60000;
    localparam logic [14:0] RST_FREQ_MAX     = 15'd20000;
    localparam logic [1:0]  RST_CURSOR       = 2'd1;
    localparam logic [6:0]  RST_DUTY         = 7'd50;
    localparam logic [14:0] RST_FREQ         = 15'd1000;
    localparam logic [15:0] RST_PRESCALER    = 16'd59;
    localparam logic [15:0] RST_COMPARE      = 16'd650;

    localparam logic [6:0] DUTY_MAX    = 7'd100;
    localparam logic [7:0] PCT_DIVISOR = 8'd100;

    // serial unit step counts
    localparam int DIV_STEPS = 16;
    localparam int MUL_STEPS = 7;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_CALC,
        CTL_EMIT
    } t_ctl_state;

    typedef enum logic [1:0] {
        TMR_IDLE,
        TMR_DIV,
        TMR_MUL,
        TMR_DONE
    } t_tmr_state;

    typedef struct packed {
        logic        start;
        logic [15:0] numer;
        logic [14:0] freq;
        logic [15:0] top;
        logic [6:0]  duty;
    } t_tmr_req;

endpackage

### src/emps_tmr.sv
module emps_tmr
    import emps_pkg::*;
#(
    parameter int TIMER_BITS = EMPS_TIMER_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_tmr_req              i_req,
    output logic                  o_done,
    output logic [TIMER_BITS-1:0] o_prescaler,
    output logic [TIMER_BITS-1:0] o_compare
);

    t_tmr_state       r_state;
    t_tmr_state       n_state;
    logic [CNT_W-1:0] r_cnt;

    // numerator / freq: dividend shifts out as quotient shifts in
    logic [15:0] r_num_q;
    logic [14:0] r_rem1;
    logic [14:0] r_div1;
    // top / 100
    logic [15:0] r_top_q;
    logic [6:0]  r_rem2;
    // shift-add multiply by duty
    logic [15:0] r_mcand;
    logic [6:0]  r_mplier;
    logic [15:0] r_acc;

    logic [15:0] w_t1;
    logic        w_ge1;
    logic [15:0] w_r1;
    logic [7:0]  w_t2;
    logic        w_ge2;
    logic [7:0]  w_r2;
    logic        w_last_div;
    logic        w_last_mul;

    assign w_t1  = {r_rem1, r_num_q[15]};
    assign w_ge1 = w_t1 >= {1'b0, r_div1};
    assign w_r1  = w_ge1 ? (w_t1 - {1'b0, r_div1}) : w_t1;
    assign w_t2  = {r_rem2, r_top_q[15]};
    assign w_ge2 = w_t2 >= PCT_DIVISOR;
    assign w_r2  = w_ge2 ? (w_t2 - PCT_DIVISOR) : w_t2;

    assign w_last_div = r_cnt == CNT_W'(DIV_STEPS - 1);
    assign w_last_mul = r_cnt == CNT_W'(MUL_STEPS - 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            TMR_IDLE: if (i_req.start) n_state = TMR_DIV;
            TMR_DIV:  if (w_last_div) n_state = TMR_MUL;
            TMR_MUL:  if (w_last_mul) n_state = TMR_DONE;
            TMR_DONE: n_state = TMR_IDLE;
            default:  n_state = TMR_IDLE;
        endcase
    end

    always_comb begin
        o_done      = r_state == TMR_DONE;
        o_prescaler = (r_num_q == 16'd0) ? '0 : TIMER_BITS'(r_num_q - 16'd1);
        o_compare   = TIMER_BITS'(r_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TMR_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == TMR_DIV && w_last_div) || r_state == TMR_IDLE) begin
                r_cnt <= '0;
            end else if (r_state == TMR_DIV || r_state == TMR_MUL) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            TMR_IDLE: begin
                if (i_req.start) begin
                    r_num_q  <= i_req.numer;
                    r_rem1   <= '0;
                    r_div1   <= i_req.freq;
                    r_top_q  <= i_req.top;
                    r_rem2   <= '0;
                    r_mplier <= i_req.duty;
                    r_acc    <= '0;
                end
            end
            TMR_DIV: begin
                r_num_q <= {r_num_q[14:0], w_ge1};
                r_rem1  <= w_r1[14:0];
                r_top_q <= {r_top_q[14:0], w_ge2};
                r_rem2  <= w_r2[6:0];
                if (w_last_div) begin
                    r_mcand <= {r_top_q[14:0], w_ge2};
                end
            end
            TMR_MUL: begin
                if (r_mplier[0]) begin
                    r_acc <= r_acc + r_mcand;
                end
                r_mcand  <= {r_mcand[14:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[6:1]};
            end
            default: ;
        endcase
    end

endmodule

### src/encoder_menu_pwm_setpoint_core.sv
// an accepted item moves from idle to the emit state and is loaded into the output register
// once the output channel is free; a select press that returns to the front page with a nonzero
// frequency first runs the timer recompute (16-step bit-serial divider, 7-step shift-add
// multiplier) before commit and output load. A new item is taken only once the last is loaded.
// reset: synchronous active low; all settings and config registers return to power-up
// values and the output channel empties

module encoder_menu_pwm_setpoint_core
    import emps_pkg::*;
#(
    parameter int TIMER_BITS = EMPS_TIMER_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] direction
    input  logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] page, [3:2] cursor, [5:4] step_size, [12:6] duty, [27:13] frequency,
    // [28] output_on, [30:29] drive_mode, [46:31] prescaler, [62:47] compare
    output logic [63:0] m_axis_tdata,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_ctl_state r_state;
    t_ctl_state n_state;

    logic [15:0] r_period_top;
    logic [15:0] r_prescale_num;
    logic [14:0] r_freq_max;

    logic [1:0]  r_page,   n_page;
    logic [1:0]  r_cursor, n_cursor;
    logic [1:0]  r_step,   n_step;
    logic [6:0]  r_duty,   n_duty;
    logic [14:0] r_freq,   n_freq;
    logic        r_on,     n_on;
    logic [1:0]  r_drive,  n_drive;
    logic [TIMER_BITS-1:0] r_prescaler;
    logic [TIMER_BITS-1:0] r_compare;
    logic        r_cmp_en;

    logic        r_out_valid;
    logic [63:0] r_out_data;

    logic        w_accept;
    logic        w_recalc;
    logic        w_out_free;
    logic        w_load;
    logic [1:0]  w_op;
    logic        w_down;

    t_tmr_req              w_req;
    logic                  w_tmr_done;
    logic [TIMER_BITS-1:0] w_tmr_presc;
    logic [TIMER_BITS-1:0] w_tmr_cmp;

    function automatic logic [14:0] bump(input logic [14:0] v, input logic [14:0] amount,
                                         input logic down, input logic [14:0] limit);
        logic [14:0] res;
        if (down) begin
            res = (v > amount) ? (v - amount) : 15'd0;
        end else if (v >= limit) begin
            res = limit;
        end else begin
            res = ((limit - v) > amount) ? (v + amount) : limit;
        end
        return res;
    endfunction

    function automatic logic [14:0] freq_step(input logic [1:0] sel);
        logic [14:0] res;
        case (sel)
            2'd0:    res = 15'd1;
            2'd1:    res = 15'd10;
            2'd2:    res = 15'd100;
            default: res = 15'd1000;
        endcase
        return res;
    endfunction

    function automatic logic [1:0] drive_of(input logic on, input logic [6:0] duty,
                                            input logic [14:0] freq);
        logic [1:0] res;
        if (!on) begin
            res = DRV_STOP;
        end else if (duty >= DUTY_MAX) begin
            res = DRV_HIGH;
        end else if (freq == 15'd0 || duty == 7'd0) begin
            res = DRV_LOW;
        end else begin
            res = DRV_RUN;
        end
        return res;
    endfunction

    assign w_op   = s_axis_tuser;
    assign w_down = s_axis_tdata[0];

    // event decode
    always_comb begin
        n_page   = r_page;
        n_cursor = r_cursor;
        n_step   = r_step;
        n_duty   = r_duty;
        n_freq   = r_freq;
        n_on     = r_on;
        n_drive  = r_drive;
        w_recalc = 1'b0;
        case (w_op)
            OP_ENC: begin
                case (r_page)
                    PAGE_FRONT: n_cursor = (r_cursor == 2'd1) ? 2'd2 : 2'd1;
                    PAGE_SETUP: begin
                        if (w_down) begin
                            n_cursor = (r_cursor > 2'd1) ? (r_cursor - 2'd1) : 2'd3;
                        end else begin
                            n_cursor = (r_cursor >= 2'd1 && r_cursor < 2'd3) ?
                                       (r_cursor + 2'd1) : 2'd1;
                        end
                    end
                    PAGE_DUTY: begin
                        n_duty = 7'(bump({8'd0, r_duty},
                                         (r_step == 2'd1) ? 15'd10 : 15'd1,
                                         w_down, {8'd0, DUTY_MAX}));
                    end
                    default: n_freq = bump(r_freq, freq_step(r_step), w_down, r_freq_max);
                endcase
            end
            OP_SEL: begin
                case (r_page)
                    PAGE_FRONT: begin
                        if (r_cursor == 2'd1) begin
                            n_on    = ~r_on;
                            n_drive = drive_of(~r_on, r_duty, r_freq);
                        end else begin
                            n_page   = PAGE_SETUP;
                            n_cursor = 2'd1;
                            n_step   = 2'd0;
                        end
                    end
                    PAGE_SETUP: begin
                        n_cursor = 2'd1;
                        n_step   = 2'd0;
                        if (r_cursor == 2'd1) begin
                            n_page = PAGE_DUTY;
                        end else if (r_cursor == 2'd2) begin
                            n_page = PAGE_FREQ;
                        end else begin
                            n_page   = PAGE_FRONT;
                            w_recalc = r_freq != 15'd0;
                        end
                    end
                    default: begin
                        n_page   = PAGE_SETUP;
                        n_cursor = 2'd1;
                        n_step   = 2'd0;
                    end
                endcase
            end
            OP_STEP: begin
                case (r_page)
                    PAGE_DUTY: n_step = (r_step == 2'd0) ? 2'd1 : 2'd0;
                    PAGE_FREQ: n_step = r_step + 2'd1;
                    default:   n_step = 2'd0;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            CTL_IDLE: begin
                if (w_accept) begin
                    n_state = w_recalc ? CTL_CALC : CTL_EMIT;
                end
            end
            CTL_CALC: if (w_tmr_done) n_state = CTL_EMIT;
            CTL_EMIT: if (w_out_free) n_state = CTL_IDLE;
            default:  n_state = CTL_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = r_state == CTL_IDLE;
        w_accept      = s_axis_tvalid && s_axis_tready;
        w_out_free    = !r_out_valid || m_axis_tready;
        w_load        = r_state == CTL_EMIT && w_out_free;
        w_req.start   = w_accept && w_recalc;
        w_req.numer   = r_prescale_num;
        w_req.freq    = r_freq;
        w_req.top     = r_period_top;
        w_req.duty    = r_duty;
    end

    emps_tmr #(
        .TIMER_BITS (TIMER_BITS)
    ) u_tmr (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .o_done      (w_tmr_done),
        .o_prescaler (w_tmr_presc),
        .o_compare   (w_tmr_cmp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= CTL_IDLE;
            r_period_top   <= RST_PERIOD_TOP;
            r_prescale_num <= RST_PRESCALE_NUM;
            r_freq_max     <= RST_FREQ_MAX;
            r_page         <= PAGE_FRONT;
            r_cursor       <= RST_CURSOR;
            r_step         <= 2'd0;
            r_duty         <= RST_DUTY;
            r_freq         <= RST_FREQ;
            r_on           <= 1'b0;
            r_drive        <= DRV_STOP;
            r_prescaler    <= TIMER_BITS'(RST_PRESCALER);
            r_compare      <= TIMER_BITS'(RST_COMPARE);
            r_cmp_en       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_PERIOD_TOP:   r_period_top   <= i_cfg_data;
                    CFG_PRESCALE_NUM: r_prescale_num <= i_cfg_data;
                    CFG_FREQ_MAX:     r_freq_max     <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_page   <= n_page;
                r_cursor <= n_cursor;
                r_step   <= n_step;
                r_duty   <= n_duty;
                r_freq   <= n_freq;
                r_on     <= n_on;
                r_drive  <= n_drive;
                // compare only moves for a duty strictly between the ends
                r_cmp_en <= r_duty != 7'd0 && r_duty < DUTY_MAX;
            end
            if (r_state == CTL_CALC && w_tmr_done) begin
                r_prescaler <= w_tmr_presc;
                if (r_cmp_en) begin
                    r_compare <= w_tmr_cmp;
                end
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_data <= {1'b0, r_compare[15:0], r_prescaler[15:0], r_drive, r_on,
                           r_freq, r_duty, r_step, r_cursor, r_page};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### src/emps_chk.sv
`include "encoder_menu_pwm_setpoint_core_assert.svh"

module emps_chk
    import emps_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    `EMPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // one item in flight: no accept on the cycle after an accept
    `EMPS_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    `EMPS_ASSERT_SAME(a_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[12:6] <= 7'd100 && m_axis_tdata[3:2] != 2'd0)

    // generator off exactly when the drive is stopped
    `EMPS_ASSERT_SAME(a_drive_on, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[28] == (m_axis_tdata[30:29] != DRV_STOP))

endmodule

bind encoder_menu_pwm_setpoint_core emps_chk u_emps_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
